FILE: hw/rtl/dgid_pkg.sv
// Shared types, constants and helper functions of the DPCM/GAP image decoder.
package dgid_pkg;

	localparam int PIX_W      = 8;
	localparam int MAX_WIDTH  = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = 16;
	localparam int ADDR_W     = COL_W + 1;
	localparam int LINE_DEPTH = 2 * MAX_WIDTH;
	localparam int RES_W      = 11;
	localparam int MODE_W     = 3;
	localparam int FW_W       = 11;
	localparam int FH_W       = 16;
	localparam int APB_AW     = 4;
	localparam int APB_DW     = 32;

	// signed working width of the predictor arithmetic
	localparam int SW = 13;
	// signed width of the gradient differences
	localparam int DW = 11;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic signed [SW-1:0] wide_t;

	// register indexes
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	// predictor modes
	localparam logic [MODE_W-1:0] MODE_WEST  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_NORTH = 3'd2;
	localparam logic [MODE_W-1:0] MODE_AVG   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_GAP   = 3'd4;

	// ternary codes carried in the residual in GAP mode
	localparam logic signed [RES_W-1:0] CODE_COPY_WEST  = -11'sd1000;
	localparam logic signed [RES_W-1:0] CODE_FIRST_DIFF = 11'sd1000;

	localparam logic signed [DW-1:0] GAP_T_STRONG = 11'sd80;
	localparam logic signed [DW-1:0] GAP_T_MID    = 11'sd32;
	localparam logic signed [DW-1:0] GAP_T_WEAK   = 11'sd8;

	localparam pix_t FIRST_BIAS = 8'd128;

	typedef struct packed {
		pix_t w;
		pix_t ww;
		pix_t n;
		pix_t nw;
		pix_t ne;
		pix_t nn;
		pix_t nne;
	} nbr_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              row_zero;
		logic              col_zero;
		logic              border;
	} pred_ctl_t;

	function automatic wide_t ext_pix(pix_t p);
		return {{(SW-PIX_W){1'b0}}, p};
	endfunction

	function automatic logic [PIX_W-1:0] abs_diff(pix_t a, pix_t b);
		return (a > b) ? a - b : b - a;
	endfunction

	// divide by 2, truncating toward zero
	function automatic wide_t div2_tz(wide_t x);
		wide_t adj;
		adj = {{(SW-1){1'b0}}, x[SW-1]};
		return (x + adj) >>> 1;
	endfunction

	// divide by 4, truncating toward zero
	function automatic wide_t div4_tz(wide_t x);
		wide_t adj;
		adj = {{(SW-2){1'b0}}, x[SW-1], x[SW-1]};
		return (x + adj) >>> 2;
	endfunction

endpackage

FILE: hw/rtl/dgid_line_mem.sv
// Two-row line buffer: one write port, two registered read ports, write-first.
module dgid_line_mem import dgid_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  pix_t              wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr_a,
	input  logic [ADDR_W-1:0] raddr_b,
	output pix_t              rdata_a,
	output pix_t              rdata_b
);

	pix_t mem_q [LINE_DEPTH];
	pix_t rdata_a_q;
	pix_t rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			// narrow frames read the pixel written at the same edge
			rdata_a_q <= (we && raddr_a == waddr) ? wdata : mem_q[raddr_a];
			rdata_b_q <= (we && raddr_b == waddr) ? wdata : mem_q[raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

FILE: hw/rtl/dgid_predict.sv
// Pixel reconstruction: predictor selection, GAP gradients and residual add.
module dgid_predict import dgid_pkg::*; (
	input  logic signed [RES_W-1:0] res,
	input  nbr_t                    nbr,
	input  pred_ctl_t               ctl,
	output pix_t                    pix
);

	logic [PIX_W+1:0] dh;
	logic [PIX_W+1:0] dv;
	logic signed [DW-1:0] d_vh;
	logic signed [DW-1:0] d_hv;
	wide_t w_s;
	wide_t n_s;
	wide_t p0;
	wide_t p1;
	wide_t res_s;
	wide_t pred;
	wide_t sum;
	pix_t  code_pix;
	logic  use_code;

	always_comb begin
		w_s   = ext_pix(nbr.w);
		n_s   = ext_pix(nbr.n);
		res_s = {{(SW-RES_W){res[RES_W-1]}}, res};

		dh = {2'b00, abs_diff(nbr.w, nbr.ww)} + {2'b00, abs_diff(nbr.n, nbr.nw)}
			+ {2'b00, abs_diff(nbr.ne, nbr.n)};
		dv = {2'b00, abs_diff(nbr.w, nbr.nw)} + {2'b00, abs_diff(nbr.n, nbr.nn)}
			+ {2'b00, abs_diff(nbr.n, nbr.nne)};
		d_vh = $signed({1'b0, dv}) - $signed({1'b0, dh});
		d_hv = $signed({1'b0, dh}) - $signed({1'b0, dv});

		p0 = ((w_s + n_s) >>> 1) + div4_tz(ext_pix(nbr.ne) - ext_pix(nbr.nw));
		priority if (d_vh > GAP_T_STRONG) begin
			p1 = w_s;
		end else if (d_hv > GAP_T_STRONG) begin
			p1 = n_s;
		end else if (d_vh > GAP_T_MID) begin
			p1 = div2_tz(p0 + w_s);
		end else if (d_hv > GAP_T_MID) begin
			p1 = div2_tz(p0 + n_s);
		end else if (d_vh > GAP_T_WEAK) begin
			p1 = div4_tz((p0 <<< 1) + p0 + w_s);
		end else if (d_hv > GAP_T_WEAK) begin
			p1 = div4_tz((p0 <<< 1) + p0 + n_s);
		end else begin
			p1 = p0;
		end

		// first neighbour that differs from west, west-west if none does
		priority if (nbr.n != nbr.w) begin
			code_pix = nbr.n;
		end else if (nbr.nn != nbr.w) begin
			code_pix = nbr.nn;
		end else if (nbr.nw != nbr.w) begin
			code_pix = nbr.nw;
		end else if (nbr.ne != nbr.w) begin
			code_pix = nbr.ne;
		end else if (nbr.nne != nbr.w) begin
			code_pix = nbr.nne;
		end else begin
			code_pix = nbr.ww;
		end

		use_code = 1'b0;
		priority if (ctl.row_zero) begin
			pred = ctl.col_zero ? ext_pix(FIRST_BIAS) : w_s;
		end else if (ctl.mode == MODE_NORTH || ctl.border) begin
			pred = n_s;
		end else if (ctl.mode == MODE_WEST) begin
			pred = w_s;
		end else if (ctl.mode == MODE_AVG) begin
			pred = ext_pix((nbr.w >> 1) + (nbr.n >> 1));
		end else begin
			pred = p1;
			if (res == CODE_COPY_WEST) begin
				use_code = 1'b1;
				code_pix = nbr.w;
			end else if (res == CODE_FIRST_DIFF) begin
				use_code = 1'b1;
			end
		end

		sum = res_s + pred;
		pix = use_code ? code_pix : sum[PIX_W-1:0];
	end

endmodule

FILE: hw/rtl/dpcm_gap_image_decoder.sv
// Top level of the DPCM/GAP image decoder: handshake, counters, window, registers.
//
// Residuals enter on the s_ channel in raster order, one per pixel; the
// reconstructed pixel leaves on the m_ channel with tlast on the last pixel
// of the frame and tuser set when the predictor mode register holds no valid
// mode (pixel 0, state untouched).
// Registers are written over the APB port: 0x0 predictor mode, 0x4 frame
// width, 0x8 frame height. Write them only while no transaction is in flight.
// A residual in the input register reaches m_tdata through the result register.
// Throughput: one pixel per cycle unless the receiver stalls. The two
// line-buffer reads for the next pixel are issued at the edge that retires
// the current one, so the neighbour window is always ready when the next
// residual sits in the input register.
// When the receiver stalls, the result register holds and the input
// register takes one more residual before s_tready drops.
// Reset clears counters, west pixels and registers to their defaults;
// the line buffer is not cleared and is written by row 0 of each frame.
module dpcm_gap_image_decoder import dgid_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,   // [10:0] residual
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // [7:0] pixel_value
	output logic              m_tlast,   // frame_last
	output logic              m_tuser,   // mode_error
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	logic [MODE_W-1:0] mode_q;
	logic [FW_W-1:0]   width_q;
	logic [FH_W-1:0]   height_q;

	logic                    v_s1;
	logic signed [RES_W-1:0] res_s1;
	logic                    mv_q;
	pix_t                    pix_q;
	logic                    last_q;
	logic                    err_q;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	pix_t             west_q;
	pix_t             west_west_q;
	pix_t             n_q;
	pix_t             nw_q;
	pix_t             nn_q;

	logic adv;
	logic fire;
	logic mode_ok;
	logic step;

	logic [FW_W-1:0]  w_eff;
	logic [FH_W-1:0]  h_eff;
	logic             last_col;
	logic             last_row;
	logic [ROW_W-1:0] next_row;
	logic [COL_W-1:0] col_p2;

	logic [ADDR_W-1:0] raddr_a;
	logic [ADDR_W-1:0] raddr_b;
	pix_t              rd_a;
	pix_t              rd_b;

	nbr_t      nbr;
	pred_ctl_t ctl;
	pix_t      pix;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_WEST;
			width_q  <= FW_W'(256);
			height_q <= FH_W'(256);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_MODE:   mode_q   <= pwdata[MODE_W-1:0];
				REG_WIDTH:  width_q  <= pwdata[FW_W-1:0];
				REG_HEIGHT: height_q <= pwdata[FH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MODE:   prdata = {{(APB_DW-MODE_W){1'b0}}, mode_q};
			REG_WIDTH:  prdata = {{(APB_DW-FW_W){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(APB_DW-FH_W){1'b0}}, height_q};
			default:    prdata = '0;
		endcase
	end

	// handshake: input register, then result register
	assign adv      = !mv_q || m_tready;
	assign s_tready = !v_s1 || adv;
	assign fire     = v_s1 && adv;
	assign mode_ok  = (mode_q == MODE_WEST) || (mode_q == MODE_NORTH)
		|| (mode_q == MODE_AVG) || (mode_q == MODE_GAP);
	assign step     = fire && mode_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			mv_q <= 1'b0;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (adv) begin
				mv_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			res_s1 <= s_tdata[RES_W-1:0];
		end
		if (fire) begin
			pix_q  <= mode_ok ? pix : '0;
			last_q <= mode_ok && last_col && last_row;
			err_q  <= !mode_ok;
		end
	end

	// frame geometry
	always_comb begin
		if (width_q == '0) begin
			w_eff = FW_W'(1);
		end else if (width_q > FW_W'(MAX_WIDTH)) begin
			w_eff = FW_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		h_eff    = (height_q == '0) ? FH_W'(1) : height_q;
		last_col = ({1'b0, col_q} + FW_W'(1)) >= w_eff;
		last_row = ({1'b0, row_q} + 17'd1) >= {1'b0, h_eff};
		next_row = last_row ? '0 : row_q + ROW_W'(1);
		col_p2   = col_q + COL_W'(2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			west_q      <= '0;
			west_west_q <= '0;
		end else if (step) begin
			west_q      <= pix;
			west_west_q <= west_q;
			if (last_col) begin
				col_q <= '0;
				row_q <= next_row;
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Prefetch for the next pixel. At column 0 both ports read the row above
	// (columns 0 and 1); elsewhere they read column+1 of the rows one and two up.
	always_comb begin
		if (last_col) begin
			raddr_a = {~next_row[0], COL_W'(0)};
			raddr_b = {~next_row[0], COL_W'(1)};
		end else begin
			raddr_a = {~row_q[0], col_p2};
			raddr_b = {row_q[0], col_p2};
		end
	end

	dgid_line_mem u_line_mem (
		.clk     (clk),
		.we      (step),
		.waddr   ({row_q[0], col_q}),
		.wdata   (pix),
		.re      (step),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// neighbour window
	always_comb begin
		nbr.w   = west_q;
		nbr.ww  = west_west_q;
		nbr.nw  = nw_q;
		nbr.nn  = nn_q;
		nbr.nne = rd_b;
		if (col_q == '0) begin
			nbr.n  = rd_a;
			nbr.ne = rd_b;
		end else begin
			nbr.n  = n_q;
			nbr.ne = rd_a;
		end
		ctl.mode     = mode_q;
		ctl.row_zero = (row_q == '0);
		ctl.col_zero = (col_q == '0);
		ctl.border   = (col_q == '0) || (col_q == COL_W'(1)) || last_col
			|| (row_q == ROW_W'(1));
	end

	always_ff @(posedge clk) begin
		if (step) begin
			n_q  <= nbr.ne;
			nw_q <= nbr.n;
			nn_q <= nbr.nne;
		end
	end

	dgid_predict u_predict (
		.res (res_s1),
		.nbr (nbr),
		.ctl (ctl),
		.pix (pix)
	);

	assign m_tvalid = mv_q;
	assign m_tdata  = pix_q;
	assign m_tlast  = last_q;
	assign m_tuser  = err_q;

endmodule
